// ===== rtl/core/row_block_matrix_multiply_core_assert.svh =====
// Assertion macros used by the core module.
`ifndef ROW_BLOCK_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define ROW_BLOCK_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// Checks that a condition implies a consequence on the same edge.
`define RBMM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that a condition implies a consequence on the next edge.
`define RBMM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/rbmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbmm_pkg
// Shared constants and types for the row band matrix multiply core.
// ----------------------------------------------------------------------------
package rbmm_pkg;
	localparam int MaxOrder = 64;
	localparam int IdxW = $clog2(MaxOrder);
	localparam int AddrW = 2 * IdxW;
	localparam int Cells = MaxOrder * MaxOrder;
	localparam int CntW = IdxW + 1;
	localparam int ElemW = 24;
	localparam int ProdW = 54;
	localparam int AccW = 2 * ElemW + IdxW + 1;

	typedef enum logic [1:0] {
		FUNC_WRITE_A = 2'd0,
		FUNC_WRITE_B = 2'd1,
		FUNC_COMPUTE = 2'd2,
		FUNC_READ = 2'd3
	} func_t;

	localparam logic [1:0] REG_ORDER = 2'd0;
	localparam logic [1:0] REG_CHUNK = 2'd1;
	localparam logic [1:0] REG_PART_INDEX = 2'd2;
	localparam logic [1:0] REG_PART_ROWS = 2'd3;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;
endpackage

// ===== rtl/core/row_block_matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// row_block_matrix_multiply_core
// Square matrix multiply over a band of rows with stores for A, B and C.
// ----------------------------------------------------------------------------
// Loads of A or B are written to their memory when accepted. A read latches
// the product memory entry, then registers it to the output. A compute first
// sweeps the product memory clear, one entry per cycle, then runs one
// multiply-accumulate per cycle through the A and B memories for each element
// of the row band, followed by pipeline drain and write-back of that element,
// then reports done once the output is free; an empty band skips to done.
// After reset the product memory is swept clear before any item is taken.
`include "row_block_matrix_multiply_core_assert.svh"

module row_block_matrix_multiply_core (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] func,
	input  logic [rbmm_pkg::IdxW-1:0] row,
	input  logic [rbmm_pkg::IdxW-1:0] col,
	input  logic signed [rbmm_pkg::ElemW-1:0] value,
	output logic out_valid,
	input  logic out_stall,
	output logic kind,
	output logic [rbmm_pkg::IdxW-1:0] row_res,
	output logic [rbmm_pkg::IdxW-1:0] col_res,
	output logic signed [rbmm_pkg::ProdW-1:0] product
);
	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_MAC, ST_DRAIN, ST_WB, ST_DONE
	} state_t;

	localparam int IW = rbmm_pkg::IdxW;
	localparam int AW = rbmm_pkg::AddrW;
	localparam int CW = rbmm_pkg::CntW;
	localparam int EW = rbmm_pkg::ElemW;
	localparam int PW = rbmm_pkg::ProdW;
	localparam int XW = rbmm_pkg::AccW;

	logic signed [EW-1:0] a_mem [rbmm_pkg::Cells];
	logic signed [EW-1:0] b_mem [rbmm_pkg::Cells];
	logic signed [PW-1:0] c_mem [rbmm_pkg::Cells];

	logic [6:0] order_q, chunk_q, part_rows_q;
	logic [5:0] part_index_q;

	state_t state_q;
	logic compute_q;
	logic [AW:0] clr_q;
	logic [CW:0] i_q, last_q;
	logic [CW-1:0] j_q, k_q, n_q;
	logic signed [EW-1:0] a_rd_s1, b_rd_s1;
	logic mac_v_s1, mac_v_s2;
	logic signed [2*EW-1:0] mul_s2;
	logic signed [XW-1:0] acc_q;
	logic signed [PW-1:0] c_rd_q;
	logic [IW-1:0] rd_row_q, rd_col_q;
	logic [IW-1:0] i_idx, j_idx, k_idx;
	logic signed [PW-1:0] sat_w;

	logic accept_in, out_free, cfg_wr;
	logic [13:0] first_w;
	logic [CW+1:0] lastsum_w;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept_in = in_valid && !in_stall;
	assign i_idx = i_q[IW-1:0];
	assign j_idx = j_q[IW-1:0];
	assign k_idx = k_q[IW-1:0];
	assign first_w = 14'(chunk_q) * 14'(part_index_q);
	assign lastsum_w = (CW+2)'(first_w > 14'(n_q) ? 14'(n_q) : first_w) +
		(CW+2)'(part_rows_q);

	always_comb begin
		if (acc_q > XW'(signed'({1'b0, {(PW-1){1'b1}}}))) begin
			sat_w = {1'b0, {(PW-1){1'b1}}};
		end else if (acc_q < XW'(signed'({1'b1, {(PW-1){1'b0}}}))) begin
			sat_w = {1'b1, {(PW-1){1'b0}}};
		end else begin
			sat_w = PW'(acc_q);
		end
	end

	always_comb begin
		case (paddr[3:2])
			rbmm_pkg::REG_ORDER: prdata = 32'(order_q);
			rbmm_pkg::REG_CHUNK: prdata = 32'(chunk_q);
			rbmm_pkg::REG_PART_INDEX: prdata = 32'(part_index_q);
			rbmm_pkg::REG_PART_ROWS: prdata = 32'(part_rows_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 7'd64;
			chunk_q <= 7'd64;
			part_index_q <= '0;
			part_rows_q <= 7'd64;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rbmm_pkg::REG_ORDER: order_q <= pwdata[6:0];
				rbmm_pkg::REG_CHUNK: chunk_q <= pwdata[6:0];
				rbmm_pkg::REG_PART_INDEX: part_index_q <= pwdata[5:0];
				rbmm_pkg::REG_PART_ROWS: part_rows_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && func == rbmm_pkg::FUNC_WRITE_A) begin
			a_mem[{row, col}] <= value;
		end
		if (accept_in && func == rbmm_pkg::FUNC_WRITE_B) begin
			b_mem[{row, col}] <= value;
		end
		a_rd_s1 <= a_mem[{i_idx, k_idx}];
		b_rd_s1 <= b_mem[{k_idx, j_idx}];
		mul_s2 <= a_rd_s1 * b_rd_s1;
		if (accept_in) begin
			c_rd_q <= c_mem[{row, col}];
		end
		if (state_q == ST_CLEAR) begin
			c_mem[clr_q[AW-1:0]] <= '0;
		end else if (state_q == ST_WB) begin
			c_mem[{i_idx, j_idx}] <= sat_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			compute_q <= 1'b0;
			clr_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			n_q <= '0;
			last_q <= '0;
			acc_q <= '0;
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
			rd_row_q <= '0;
			rd_col_q <= '0;
			out_valid <= 1'b0;
			kind <= 1'b0;
			row_res <= '0;
			col_res <= '0;
			product <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_DONE && state_q != ST_READ) begin
				out_valid <= 1'b0;
			end
			mac_v_s1 <= (state_q == ST_MAC);
			mac_v_s2 <= mac_v_s1;
			if (mac_v_s2) begin
				acc_q <= acc_q + XW'(mul_s2);
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == (AW+1)'(rbmm_pkg::Cells - 1)) begin
						clr_q <= '0;
						if (!compute_q) begin
							state_q <= ST_IDLE;
						end else if (first_w < 14'(n_q) && part_rows_q != '0) begin
							i_q <= (CW+1)'(first_w);
							last_q <= lastsum_w > (CW+2)'(n_q) ? (CW+1)'(n_q)
								: (CW+1)'(lastsum_w);
							j_q <= '0;
							k_q <= '0;
							acc_q <= '0;
							state_q <= ST_MAC;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept_in) begin
						case (func)
							rbmm_pkg::FUNC_COMPUTE: begin
								n_q <= order_q > 7'(rbmm_pkg::MaxOrder)
									? CW'(rbmm_pkg::MaxOrder) : CW'(order_q);
								compute_q <= 1'b1;
								state_q <= ST_CLEAR;
							end
							rbmm_pkg::FUNC_READ: begin
								rd_row_q <= row;
								rd_col_q <= col;
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					out_valid <= 1'b1;
					kind <= rbmm_pkg::KIND_READ;
					row_res <= rd_row_q;
					col_res <= rd_col_q;
					product <= c_rd_q;
					state_q <= ST_IDLE;
				end
				ST_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_v_s1 && !mac_v_s2) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					acc_q <= '0;
					k_q <= '0;
					if (j_q == n_q - 1'b1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 == last_q) ? ST_DONE : ST_MAC;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= ST_MAC;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						kind <= rbmm_pkg::KIND_DONE;
						row_res <= '0;
						col_res <= '0;
						product <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`RBMM_ASSERT_IMPL(a_stall_busy, state_q != ST_IDLE, in_stall)
	`RBMM_ASSERT_NEXT(a_read_out, state_q == ST_READ, out_valid && kind == rbmm_pkg::KIND_READ)
	`RBMM_ASSERT_NEXT(a_done_out, state_q == ST_DONE && out_free, out_valid && kind == rbmm_pkg::KIND_DONE)
	`RBMM_ASSERT_IMPL(a_mac_idle, state_q == ST_IDLE, !mac_v_s2)
endmodule

// ===== verif/row_block_matrix_multiply_core_tb.sv =====
// ----------------------------------------------------------------------------
// row_block_matrix_multiply_core_tb
// Self-checking testbench for the row band matrix multiply core. Phases load
// A and B for the chosen order, compute a band of rows and read the product back,
// with random idling on both sides; a behavioral model predicts each result.
// ----------------------------------------------------------------------------
module row_block_matrix_multiply_core_tb;
	localparam int IW = rbmm_pkg::IdxW;
	localparam int EW = rbmm_pkg::ElemW;
	localparam int PW = rbmm_pkg::ProdW;
	localparam int MO = rbmm_pkg::MaxOrder;
	localparam int NC = rbmm_pkg::Cells;

	typedef struct {
		rbmm_pkg::func_t fn;
		logic [IW-1:0] r;
		logic [IW-1:0] c;
		logic signed [EW-1:0] v;
	} mm_item_t;

	typedef struct {
		logic k;
		logic [IW-1:0] r;
		logic [IW-1:0] c;
		logic signed [PW-1:0] p;
	} mm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = rbmm_pkg::FUNC_WRITE_A;
	logic [IW-1:0] row = '0;
	logic [IW-1:0] col = '0;
	logic signed [EW-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [IW-1:0] row_res;
	logic [IW-1:0] col_res;
	logic signed [PW-1:0] product;

	mm_item_t pending_items_q[$];
	mm_result_t expected_results_q[$];
	mm_item_t cur_item;
	logic signed [EW-1:0] a_mem[NC];
	logic signed [EW-1:0] b_mem[NC];
	longint c_mem[NC];
	logic [6:0] cfg_order = 7'd64;
	logic [6:0] cfg_chunk = 7'd64;
	logic [5:0] cfg_part_index = 6'd0;
	logic [6:0] cfg_part_rows = 7'd64;
	int fail_count = 0;
	int items_queued = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit quiet = 1'b0;

	always #5 clk = ~clk;

	row_block_matrix_multiply_core u_top (.*);

	function automatic void compute_product_band();
		int n;
		int first;
		int last;
		longint acc;
		n = (cfg_order > MO) ? MO : int'(cfg_order);
		first = int'(cfg_chunk) * int'(cfg_part_index);
		last = first + int'(cfg_part_rows);
		if (last > n)
			last = n;
		for (int i = 0; i < NC; i++)
			c_mem[i] = 0;
		for (int i = first; i < last; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = 0;
				for (int k = 0; k < n; k++)
					acc += longint'(a_mem[i * MO + k]) * longint'(b_mem[k * MO + j]);
				c_mem[i * MO + j] = acc;
			end
		end
	endfunction

	function automatic void matmul_step(mm_item_t it);
		mm_result_t res;
		int idx;
		idx = int'(it.r) * MO + int'(it.c);
		case (it.fn)
			rbmm_pkg::FUNC_WRITE_A: a_mem[idx] = it.v;
			rbmm_pkg::FUNC_WRITE_B: b_mem[idx] = it.v;
			rbmm_pkg::FUNC_COMPUTE: begin
				compute_product_band();
				res.k = rbmm_pkg::KIND_DONE;
				res.r = '0;
				res.c = '0;
				res.p = '0;
				expected_results_q.push_back(res);
			end
			default: begin
				res.k = rbmm_pkg::KIND_READ;
				res.r = it.r;
				res.c = it.c;
				res.p = c_mem[idx][PW-1:0];
				expected_results_q.push_back(res);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				matmul_step(cur_item);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_items_q.size() > 0) begin
					cur_item = pending_items_q.pop_front();
					func <= cur_item.fn;
					row <= cur_item.r;
					col <= cur_item.c;
					value <= cur_item.v;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0)
						in_gap = $urandom_range(1, 6);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		mm_result_t exp_res;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results_q.size() == 0) begin
					$error("unexpected result kind=%0d row=%0d col=%0d", kind, row_res, col_res);
					fail_count++;
				end else begin
					exp_res = expected_results_q.pop_front();
					if (kind !== exp_res.k) begin
						$error("kind: expected %0d actual %0d", exp_res.k, kind);
						fail_count++;
					end
					if (row_res !== exp_res.r) begin
						$error("row_res: expected %0d actual %0d", exp_res.r, row_res);
						fail_count++;
					end
					if (col_res !== exp_res.c) begin
						$error("col_res: expected %0d actual %0d", exp_res.c, col_res);
						fail_count++;
					end
					if (product !== exp_res.p) begin
						$error("product: expected %0d actual %0d", exp_res.p, product);
						fail_count++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rbmm_pkg::REG_ORDER: cfg_order = data[6:0];
			rbmm_pkg::REG_CHUNK: cfg_chunk = data[6:0];
			rbmm_pkg::REG_PART_INDEX: cfg_part_index = data[5:0];
			default: cfg_part_rows = data[6:0];
		endcase
	endtask

	task automatic queue_item(rbmm_pkg::func_t fn, int r, int c, logic signed [EW-1:0] v);
		mm_item_t it;
		it.fn = fn;
		it.r = r[IW-1:0];
		it.c = c[IW-1:0];
		it.v = v;
		pending_items_q.push_back(it);
		items_queued++;
	endtask

	function automatic logic signed [EW-1:0] pick_value(bit extreme);
		if (extreme)
			return $urandom_range(0, 1) ? 24'sh800000 : 24'sh7fffff;
		return EW'($urandom());
	endfunction

	task automatic wait_idle();
		while (pending_items_q.size() > 0 || in_valid || expected_results_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// One phase: set the band, load A and B as far as the band needs, compute,
	// then read the product back.
	task automatic run_band(int ord, int chunk, int pidx, int prows, int nreads,
		int noise, bit extreme);
		int n;
		int first;
		int last;
		int load_n;
		int k;
		write_register(rbmm_pkg::REG_ORDER, ord);
		write_register(rbmm_pkg::REG_CHUNK, chunk);
		write_register(rbmm_pkg::REG_PART_INDEX, pidx);
		write_register(rbmm_pkg::REG_PART_ROWS, prows);
		n = (ord > MO) ? MO : ord;
		first = chunk * pidx;
		last = (first + prows > n) ? n : first + prows;
		load_n = (first < last) ? n : 0;
		for (int i = 0; i < load_n; i++)
			for (int j = 0; j < load_n; j++) begin
				queue_item(rbmm_pkg::FUNC_WRITE_A, i, j, pick_value(extreme));
				queue_item(rbmm_pkg::FUNC_WRITE_B, i, j, pick_value(extreme));
				if ($urandom_range(0, 15) == 0)
					queue_item(rbmm_pkg::FUNC_READ, $urandom_range(0, 63),
						$urandom_range(0, 63), pick_value(1'b0));
			end
		for (int i = 0; i < noise; i++) begin
			k = $urandom_range(0, 2);
			if (k == 2)
				queue_item(rbmm_pkg::FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_value(1'b0));
			else
				queue_item(k ? rbmm_pkg::FUNC_WRITE_B : rbmm_pkg::FUNC_WRITE_A,
					$urandom_range(0, 63), $urandom_range(0, 63), pick_value(1'b0));
		end
		queue_item(rbmm_pkg::FUNC_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
			pick_value(1'b0));
		for (int i = 0; i < nreads; i++) begin
			if (n > 0 && $urandom_range(0, 3) != 0)
				queue_item(rbmm_pkg::FUNC_READ, $urandom_range(0, n - 1),
					$urandom_range(0, n - 1), pick_value(1'b0));
			else
				queue_item(rbmm_pkg::FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_value(1'b0));
		end
		wait_idle();
	endtask

	initial begin
		int ord;
		for (int i = 0; i < NC; i++) begin
			a_mem[i] = '0;
			b_mem[i] = '0;
			c_mem[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run_band(1, 64, 0, 64, 3, 0, 1'b1);
		run_band(2, 1, 1, 1, 4, 0, 1'b1);
		run_band(0, 0, 63, 0, 2, 0, 1'b0);
		run_band(127, 127, 63, 127, 2, 0, 1'b0);
		run_band(3, 0, 5, 2, 3, 0, 1'b0);
		while (items_queued < 1550) begin
			if (items_queued > 1350)
				quiet = 1'b1;
			ord = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			if ($urandom_range(0, 9) == 0)
				run_band($urandom_range(0, 127), $urandom_range(8, 127), $urandom_range(8, 63),
					$urandom_range(0, 127), $urandom_range(2, 10), $urandom_range(0, 10), 1'b0);
			else
				run_band(ord, $urandom_range(0, ord), $urandom_range(0, 3),
					$urandom_range(0, ord + 2), $urandom_range(5, 25), $urandom_range(0, 15),
					$urandom_range(0, 7) == 0);
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_results_q.size() == 0)
			$display("row_block_matrix_multiply_core_tb passed");
		else
			$display("row_block_matrix_multiply_core_tb failed");
		$finish;
	end

	initial begin
		#40000000;
		$display("row_block_matrix_multiply_core_tb failed");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rbmm_pkg.sv
rtl/core/row_block_matrix_multiply_core.sv
verif/row_block_matrix_multiply_core_tb.sv
